/* rtl/aabb_pkg.sv */
// aabb_pkg: operation codes, box record layout and datapath widths
// shared by the collision world top level and its divider
// no dependencies
package aabb_pkg;

  localparam logic [2:0] KIND_ADD     = 3'd0;
  localparam logic [2:0] KIND_CLEAR   = 3'd1;
  localparam logic [2:0] KIND_MOVE    = 3'd2;
  localparam logic [2:0] KIND_OVERLAP = 3'd3;
  localparam logic [2:0] KIND_RAY     = 3'd4;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam int POS_W  = 32;
  localparam int HALF_W = 31;
  // slab numerator: (bound - origin) scaled by 2^16
  localparam int NUM_W  = 51;
  localparam int DEN_W  = 32;

  typedef struct packed {
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic signed [POS_W-1:0] cz;
    logic [HALF_W-1:0]       hx;
    logic [HALF_W-1:0]       hy;
    logic [HALF_W-1:0]       hz;
  } box_t;

  localparam int BOX_W = $bits(box_t);

endpackage

/* rtl/aabb_ram.sv */
// aabb_ram: generic single write port, single read port ram
// read data registered; no dependencies
module aabb_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                           wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                           rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* rtl/aabb_div.sv */
// aabb_div: iterative signed divider, one quotient bit per cycle,
// quotient truncated toward zero; depends on aabb_pkg widths
module aabb_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [aabb_pkg::NUM_W-1:0]    num,
  input  logic signed [aabb_pkg::DEN_W-1:0]    den,
  output logic                                 done,
  output logic signed [aabb_pkg::NUM_W-1:0]    quo
);
  import aabb_pkg::*;

  localparam int MAG_W = NUM_W - 1;
  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0]   dvd;
  logic [DEN_W-1:0]   rem;
  logic [DEN_W-1:0]   dmag;
  logic               neg;
  logic               run;
  logic [CNT_W-1:0]   cnt;
  logic [DEN_W:0]     trial;
  logic               qbit;
  logic [MAG_W-1:0]   dvd_next;
  logic [DEN_W-1:0]   rem_next;
  logic [NUM_W-1:0]   num_abs;
  logic [DEN_W-1:0]   den_abs;

  always_comb begin
    num_abs  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    den_abs  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    trial    = {rem, dvd[MAG_W-1]};
    qbit     = (trial >= {1'b0, dmag});
    rem_next = qbit ? DEN_W'(trial - {1'b0, dmag}) : trial[DEN_W-1:0];
    dvd_next = {dvd[MAG_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        cnt  <= '0;
        dvd  <= num_abs[MAG_W-1:0];
        rem  <= '0;
        dmag <= den_abs;
        neg  <= num[NUM_W-1] ^ den[DEN_W-1];
      end else if (run) begin
        dvd <= dvd_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MAG_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
          quo  <= neg ? -$signed({1'b0, dvd_next}) : $signed({1'b0, dvd_next});
        end
      end
    end
  end
endmodule

/* rtl/aabb_collision_world.sv */
// aabb collision world: add stores one box, clear empties the table, unknown kinds
// return zeros. overlap scans the boxes to the first hit; move: 3 axes over every
// stored box, then a ground check. raycast: per box 6 divisions in the shared serial
// divider, the shared multiplier on a new closest hit; the divider sets the ray rate.
// one transaction at a time while busy; done pulses one cycle with the result.
// synchronous reset empties the table at once; box storage is not cleared.
module aabb_collision_world #(
  parameter int MAX_BOXES = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        kind,
  input  logic signed [aabb_pkg::POS_W-1:0] pos_x,
  input  logic signed [aabb_pkg::POS_W-1:0] pos_y,
  input  logic signed [aabb_pkg::POS_W-1:0] pos_z,
  input  logic [aabb_pkg::HALF_W-1:0]       half_x,
  input  logic [aabb_pkg::HALF_W-1:0]       half_y,
  input  logic [aabb_pkg::HALF_W-1:0]       half_z,
  input  logic signed [aabb_pkg::POS_W-1:0] vec_x,
  input  logic signed [aabb_pkg::POS_W-1:0] vec_y,
  input  logic signed [aabb_pkg::POS_W-1:0] vec_z,
  input  logic [aabb_pkg::HALF_W-1:0]       max_dist,
  output logic                              done,
  output logic                              hit,
  output logic signed [aabb_pkg::POS_W-1:0] out_x,
  output logic signed [aabb_pkg::POS_W-1:0] out_y,
  output logic signed [aabb_pkg::POS_W-1:0] out_z,
  output logic [aabb_pkg::HALF_W-1:0]       distance,
  output logic [7:0]                        body_index,
  output logic [1:0]                        normal_axis,
  output logic                              normal_negative,
  output logic                              table_full
);
  import aabb_pkg::*;

  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_ADD    = 5'd1;
  localparam logic [4:0] S_ZERO   = 5'd2;
  localparam logic [4:0] MV_AX    = 5'd3;
  localparam logic [4:0] MV_RD    = 5'd4;
  localparam logic [4:0] MV_CHK   = 5'd5;
  localparam logic [4:0] MV_PUSH  = 5'd6;
  localparam logic [4:0] MV_END   = 5'd7;
  localparam logic [4:0] MV_GND   = 5'd8;
  localparam logic [4:0] OV_RD    = 5'd9;
  localparam logic [4:0] OV_CHK   = 5'd10;
  localparam logic [4:0] RC_BEG   = 5'd11;
  localparam logic [4:0] RC_RD    = 5'd12;
  localparam logic [4:0] RC_SL    = 5'd13;
  localparam logic [4:0] RC_DW    = 5'd14;
  localparam logic [4:0] RC_EV    = 5'd15;
  localparam logic [4:0] RC_PM    = 5'd16;
  localparam logic [4:0] RC_PC    = 5'd17;
  localparam logic [4:0] RC_L     = 5'd18;
  localparam logic [4:0] RC_NM    = 5'd19;
  localparam logic [4:0] RC_NX    = 5'd20;

  logic [4:0]               state;
  logic [CW-1:0]            box_count;
  logic [CW-1:0]            idx;
  logic [1:0]               ax;
  logic                     grounded;

  logic signed [31:0]       p [3];
  logic [30:0]              h [3];
  logic signed [31:0]       v [3];
  logic [30:0]              maxd;
  logic signed [35:0]       c [3];

  logic                     ov_r;
  logic signed [36:0]       diff_r;
  logic [32:0]              sumh_r;

  logic [2:0]               slab;
  logic signed [NUM_W-1:0]  t1, tmin, tmax;
  logic [30:0]              best;
  logic [30:0]              t_r;
  logic                     any;
  logic [CW-1:0]            bi;
  logic [3:0]               k;
  logic signed [31:0]       pt [3];
  logic [32:0]              l [3];
  logic                     pos [3];
  logic [63:0]              np [6];
  logic [1:0]               naxis;

  logic                     ram_we, ram_re;
  logic [BOX_W-1:0]         rdata;
  box_t                     bx, wbox;
  logic signed [31:0]       bc [3];
  logic [30:0]              bh [3];

  logic                     div_start, div_done;
  logic signed [NUM_W-1:0]  div_num, div_quo;
  logic signed [DEN_W-1:0]  div_den;

  logic signed [33:0]       mul_a, mul_b;
  logic signed [67:0]       prod;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

  // strict overlap on all three axes against one stored box
  function automatic logic box_ov(input logic signed [35:0] c0, input logic signed [35:0] c1,
                                  input logic signed [35:0] c2, input logic [30:0] h0,
                                  input logic [30:0] h1, input logic [30:0] h2,
                                  input box_t b);
    logic signed [37:0] cc [3];
    logic signed [37:0] hh [3];
    logic signed [37:0] bcc [3];
    logic signed [37:0] bhh [3];
    logic ok;
    cc[0] = 38'(c0); cc[1] = 38'(c1); cc[2] = 38'(c2);
    hh[0] = $signed({7'b0, h0}); hh[1] = $signed({7'b0, h1}); hh[2] = $signed({7'b0, h2});
    bcc[0] = 38'(b.cx); bcc[1] = 38'(b.cy); bcc[2] = 38'(b.cz);
    bhh[0] = $signed({7'b0, b.hx}); bhh[1] = $signed({7'b0, b.hy});
    bhh[2] = $signed({7'b0, b.hz});
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (!((cc[a] - hh[a]) < (bcc[a] + bhh[a]) && (cc[a] + hh[a]) > (bcc[a] - bhh[a]))) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  assign busy = (state != S_IDLE);
  assign bx   = box_t'(rdata);

  always_comb begin
    bc[0] = bx.cx; bc[1] = bx.cy; bc[2] = bx.cz;
    bh[0] = bx.hx; bh[1] = bx.hy; bh[2] = bx.hz;
    wbox  = '{cx: p[0], cy: p[1], cz: p[2], hx: h[0], hy: h[1], hz: h[2]};
    ram_we = (state == S_ADD) && (box_count < CW'(MAX_BOXES));
    ram_re = (state == MV_RD) || (state == OV_RD) || (state == RC_RD);
  end

  aabb_ram #(.W(BOX_W), .DEPTH(MAX_BOXES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (box_count[AW-1:0]),
    .wdata (wbox),
    .re    (ram_re),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  // slab numerator and divisor for the current bound
  logic signed [33:0] bnd;
  logic signed [34:0] rel;
  logic [1:0]         sax;
  always_comb begin
    sax = slab[2:1];
    if (slab[0]) begin
      bnd = 34'(bc[sax]) + $signed({3'b0, bh[sax]});
    end else begin
      bnd = 34'(bc[sax]) - $signed({3'b0, bh[sax]});
    end
    rel       = 35'(bnd) - 35'(p[sax]);
    div_num   = $signed({rel, 16'h0000});
    div_den   = (v[sax] == 32'sd0) ? 32'sd1 : v[sax];
    div_start = (state == RC_SL);
  end

  aabb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // shared multiplier operand select: hit point, then normal cross products
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (k)
      4'd0:    begin mul_a = 34'(v[0]); mul_b = $signed({3'b0, t_r}); end
      4'd1:    begin mul_a = 34'(v[1]); mul_b = $signed({3'b0, t_r}); end
      4'd2:    begin mul_a = 34'(v[2]); mul_b = $signed({3'b0, t_r}); end
      4'd3:    begin mul_a = $signed({1'b0, l[0]}); mul_b = $signed({3'b0, bh[1]}); end
      4'd4:    begin mul_a = $signed({1'b0, l[1]}); mul_b = $signed({3'b0, bh[0]}); end
      4'd5:    begin mul_a = $signed({1'b0, l[0]}); mul_b = $signed({3'b0, bh[2]}); end
      4'd6:    begin mul_a = $signed({1'b0, l[2]}); mul_b = $signed({3'b0, bh[0]}); end
      4'd7:    begin mul_a = $signed({1'b0, l[1]}); mul_b = $signed({3'b0, bh[2]}); end
      4'd8:    begin mul_a = $signed({1'b0, l[2]}); mul_b = $signed({3'b0, bh[1]}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  logic signed [63:0]      prod64, q64, sum64;
  logic signed [NUM_W-1:0] lo, hi, best_s, t_sel;
  logic [36:0]             absd;
  logic signed [37:0]      pen;
  logic signed [32:0]      gnd;
  logic signed [32:0]      dl [3];
  always_comb begin
    prod64 = prod[63:0];
    q64    = (prod64 + (prod64[63] ? 64'sd65535 : 64'sd0)) >>> 16;
    sum64  = 64'(p[k[1:0]]) + q64;
    lo     = (t1 < div_quo) ? t1 : div_quo;
    hi     = (t1 < div_quo) ? div_quo : t1;
    best_s = $signed({20'b0, best});
    t_sel  = (tmin >= 0) ? tmin : tmax;
    absd   = diff_r[36] ? 37'(-diff_r) : 37'(diff_r);
    pen    = $signed({5'b0, sumh_r}) - $signed({1'b0, absd});
    gnd    = 33'(p[1]) - $signed({2'b0, h[1]});
    for (int a = 0; a < 3; a++) begin
      dl[a] = 33'(pt[a]) - 33'(bc[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      box_count <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            p[0] <= pos_x; p[1] <= pos_y; p[2] <= pos_z;
            h[0] <= half_x; h[1] <= half_y; h[2] <= half_z;
            v[0] <= vec_x; v[1] <= vec_y; v[2] <= vec_z;
            maxd <= max_dist;
            idx  <= '0;
            ax   <= AXIS_X;
            grounded <= 1'b0;
            priority if (kind == KIND_ADD) begin
              state <= S_ADD;
            end else if (kind == KIND_CLEAR) begin
              box_count <= '0;
              state     <= S_ZERO;
            end else if (kind == KIND_MOVE) begin
              state <= MV_AX;
            end else if (kind == KIND_OVERLAP) begin
              state <= (box_count == '0) ? S_ZERO : OV_RD;
            end else if (kind == KIND_RAY) begin
              state <= RC_BEG;
            end else begin
              state <= S_ZERO;
            end
          end
        end
        S_ADD: begin
          hit <= 1'b0; out_x <= '0; out_y <= '0; out_z <= '0; distance <= '0;
          normal_axis <= AXIS_X; normal_negative <= 1'b0;
          if (box_count < CW'(MAX_BOXES)) begin
            body_index <= 8'(box_count);
            table_full <= 1'b0;
            box_count  <= box_count + 1'b1;
          end else begin
            body_index <= '0;
            table_full <= 1'b1;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_ZERO: begin
          hit <= 1'b0; out_x <= '0; out_y <= '0; out_z <= '0; distance <= '0;
          body_index <= '0; normal_axis <= AXIS_X; normal_negative <= 1'b0;
          table_full <= 1'b0;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        MV_AX: begin
          // only the current axis takes the displacement
          for (int b = 0; b < 3; b++) begin
            c[b] <= (b == int'(ax)) ? 36'(p[b]) + 36'(v[b]) : 36'(p[b]);
          end
          idx   <= '0;
          state <= (box_count == '0) ? MV_END : MV_RD;
        end
        MV_RD: begin
          state <= MV_CHK;
        end
        MV_CHK: begin
          ov_r   <= box_ov(c[0], c[1], c[2], h[0], h[1], h[2], bx);
          diff_r <= 37'(c[ax]) - 37'(bc[ax]);
          sumh_r <= 33'(h[ax]) + 33'(bh[ax]);
          state  <= MV_PUSH;
        end
        MV_PUSH: begin
          if (ov_r && pen > 0) begin
            if (diff_r > 0) begin
              c[ax] <= 36'(38'(c[ax]) + pen);
              if (ax == AXIS_Y) begin
                grounded <= 1'b1;
              end
            end else begin
              c[ax] <= 36'(38'(c[ax]) - pen);
            end
          end
          if (CW'(idx + 1'b1) == box_count) begin
            state <= MV_END;
          end else begin
            idx   <= idx + 1'b1;
            state <= MV_RD;
          end
        end
        MV_END: begin
          p[ax] <= sat32(64'(c[ax]));
          if (ax == AXIS_Z) begin
            state <= MV_GND;
          end else begin
            ax    <= ax + 1'b1;
            state <= MV_AX;
          end
        end
        MV_GND: begin
          out_x <= p[0];
          out_z <= p[2];
          if (gnd < 0) begin
            out_y <= $signed({1'b0, h[1]});
            hit   <= 1'b1;
          end else begin
            out_y <= p[1];
            hit   <= grounded;
          end
          distance <= '0; body_index <= '0; normal_axis <= AXIS_X;
          normal_negative <= 1'b0; table_full <= 1'b0;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        OV_RD: begin
          state <= OV_CHK;
        end
        OV_CHK: begin
          if (box_ov(36'(p[0]), 36'(p[1]), 36'(p[2]), h[0], h[1], h[2], bx) ||
              CW'(idx + 1'b1) == box_count) begin
            hit <= box_ov(36'(p[0]), 36'(p[1]), 36'(p[2]), h[0], h[1], h[2], bx);
            out_x <= '0; out_y <= '0; out_z <= '0; distance <= '0;
            body_index <= '0; normal_axis <= AXIS_X; normal_negative <= 1'b0;
            table_full <= 1'b0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= OV_RD;
          end
        end
        RC_BEG: begin
          best  <= maxd;
          any   <= 1'b0;
          bi    <= '0;
          naxis <= AXIS_X;
          for (int a = 0; a < 3; a++) begin
            pt[a]  <= '0;
            pos[a] <= 1'b0;
          end
          state <= (box_count == '0) ? RC_NX : RC_RD;
        end
        RC_RD: begin
          slab  <= '0;
          state <= RC_SL;
        end
        RC_SL: begin
          state <= RC_DW;
        end
        RC_DW: begin
          if (div_done) begin
            if (!slab[0]) begin
              t1 <= div_quo;
            end else if (slab[2:1] == AXIS_X) begin
              tmin <= lo;
              tmax <= hi;
            end else begin
              if (lo > tmin) tmin <= lo;
              if (hi < tmax) tmax <= hi;
            end
            if (slab == 3'd5) begin
              state <= RC_EV;
            end else begin
              slab  <= slab + 1'b1;
              state <= RC_SL;
            end
          end
        end
        RC_EV: begin
          if (tmax < 0 || tmin > tmax || tmin > best_s || !(t_sel < best_s)) begin
            state <= RC_NX;
          end else begin
            best  <= t_sel[30:0];
            t_r   <= t_sel[30:0];
            bi    <= idx;
            any   <= 1'b1;
            k     <= '0;
            state <= RC_PM;
          end
        end
        RC_PM: begin
          state <= RC_PC;
        end
        RC_PC: begin
          if (k < 4'd3) begin
            pt[k[1:0]] <= sat32(sum64);
          end else begin
            np[3'(k - 4'd3)] <= prod[63:0];
          end
          if (k == 4'd2) begin
            state <= RC_L;
          end else if (k == 4'd8) begin
            state <= RC_NM;
          end else begin
            k     <= k + 1'b1;
            state <= RC_PM;
          end
        end
        RC_L: begin
          for (int a = 0; a < 3; a++) begin
            l[a]   <= dl[a][32] ? 33'(-dl[a]) : 33'(dl[a]);
            pos[a] <= (dl[a] > 0);
          end
          k     <= 4'd3;
          state <= RC_PM;
        end
        RC_NM: begin
          // dominant face from cross-multiplied ratios
          if (np[0] > np[1] && np[2] > np[3]) begin
            naxis <= AXIS_X;
          end else if (np[4] > np[5]) begin
            naxis <= AXIS_Y;
          end else begin
            naxis <= AXIS_Z;
          end
          state <= RC_NX;
        end
        RC_NX: begin
          if (box_count == '0 || CW'(idx + 1'b1) == box_count) begin
            hit        <= any;
            out_x      <= any ? pt[0] : '0;
            out_y      <= any ? pt[1] : '0;
            out_z      <= any ? pt[2] : '0;
            distance   <= best;
            body_index <= any ? 8'(bi) : '0;
            normal_axis     <= any ? naxis : AXIS_X;
            normal_negative <= any && !pos[naxis];
            table_full <= 1'b0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= RC_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_fall_done: assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("busy dropped without a result strobe");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");
  a_count_max: assert property (@(posedge clk) disable iff (rst) box_count <= CW'(MAX_BOXES))
    else $error("box count above table depth");
  a_full_only: assert property (@(posedge clk) disable iff (rst)
    (done && table_full) |-> (box_count == CW'(MAX_BOXES)))
    else $error("table full flagged with free entries");
`endif

endmodule
